// File: rtl/core/kll_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed linked list engine: word types, action and status codes,
// and the command that drives the storage cells. No dependencies.
package kll_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned POS_W = 7;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;
	localparam logic [1:0] ACT_PRINT  = 2'd3;

	localparam logic [3:0] ST_DONE     = 4'd0;
	localparam logic [3:0] ST_EXISTS   = 4'd1;
	localparam logic [3:0] ST_NOPOS    = 4'd2;
	localparam logic [3:0] ST_NOTFOUND = 4'd3;
	localparam logic [3:0] ST_FULL     = 4'd4;
	localparam logic [3:0] ST_PREVKEY  = 4'd5;
	localparam logic [3:0] ST_PREVHEAD = 4'd6;
	localparam logic [3:0] ST_EMPTY    = 4'd7;
	localparam logic [3:0] ST_ITEM     = 4'd8;

	localparam logic signed [KEY_W-1:0] HEAD_KEY = '1;

	typedef struct packed {
		logic [1:0]              action;
		logic signed [KEY_W-1:0] key;
		logic signed [KEY_W-1:0] after_key;
	} req_t;

	typedef struct packed {
		logic [3:0]              status;
		logic signed [KEY_W-1:0] value;
		logic                    last;
	} rsp_t;

	typedef struct packed {
		logic                    vld;
		logic signed [KEY_W-1:0] key;
	} cell_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_ROT  = 2'd1,
		CELL_INS  = 2'd2,
		CELL_DEL  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]        at;
	} cell_cmd_t;

endpackage

// File: rtl/core/keyed_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// Keyed linked list engine: ordered list of distinct signed keys held in a row of cells.
// Depends on kll_pkg and kll_cell.
//
// Usage:
//   req (valid/ready) carries one word: action, key, after_key. rsp (valid/ready)
//   returns status, value, last. Insert, delete and find return one word; print
//   returns one word per listed key with last on the final one, or one empty word.
//   The list sits in CAPACITY cells in list order. A request rotates the whole row
//   one cell per cycle past cell 0 (unless paused, see below), comparing each key
//   there, through a full turn, then decides and shifts the row for insert or delete.
//   One request is handled at a time: the next is accepted only once the engine has
//   returned to idle.
//   A stalled receiver holds the output register; a print waiting on it pauses
//   the rotation, and other requests wait in the done state.
//   Reset empties the list and drops any pending word.
module keyed_linked_list_engine_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kll_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kll_pkg::rsp_t rsp
);

	localparam int unsigned IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned PW    = kll_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                           state_q;
	logic [IW-1:0]                    step_q;
	logic [CNT_W-1:0]                 count_q;
	logic                             hit_q;
	logic                             pos_q;
	logic [IW-1:0]                    hit_idx_q;
	logic [IW-1:0]                    pos_idx_q;
	logic [1:0]                       act_q;
	logic signed [kll_pkg::KEY_W-1:0] key_q;
	logic signed [kll_pkg::KEY_W-1:0] after_q;
	logic signed [kll_pkg::KEY_W-1:0] prev_key_q;
	logic                             rsp_valid_q;
	kll_pkg::rsp_t                    rsp_q;

	kll_pkg::cell_t     cells [CAPACITY];
	kll_pkg::cell_t     lo    [CAPACITY];
	kll_pkg::cell_t     hi    [CAPACITY];
	kll_pkg::cell_cmd_t cmd;
	kll_pkg::cell_t     c0;
	kll_pkg::cell_t     empty_cell;
	logic               nxt_vld;

	logic            out_free;
	logic            adv;
	logic            scan_end;
	logic            is_print;
	logic            commit;
	logic [3:0]      res_status;
	logic signed [kll_pkg::KEY_W-1:0] res_value;
	logic            emit;
	logic            do_ins;
	logic            do_del;
	logic [PW-1:0]   at;

	assign empty_cell = '0;
	assign c0         = cells[0];

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_lo_end
				assign lo[gi] = empty_cell;
			end else begin : g_lo
				assign lo[gi] = cells[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_hi_end
				assign hi[gi] = (cmd.op == kll_pkg::CELL_ROT) ? cells[0] : empty_cell;
			end else begin : g_hi
				assign hi[gi] = cells[gi+1];
			end
			kll_cell #(
				.IDX (gi)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.lo     (lo[gi]),
				.hi     (hi[gi]),
				.q      (cells[gi])
			);
		end
		if (CAPACITY > 1) begin : g_nxt
			assign nxt_vld = cells[1].vld;
		end else begin : g_nxt_none
			assign nxt_vld = 1'b0;
		end
	endgenerate

	assign out_free = !rsp_valid_q || rsp_ready;
	assign is_print = (act_q == kll_pkg::ACT_PRINT);
	assign adv      = (state_q == S_SCAN) && !(is_print && c0.vld && !out_free);
	assign scan_end = (step_q == IW'(CAPACITY - 1));
	assign commit   = (state_q == S_DONE) && out_free;

	always_comb begin
		res_status = kll_pkg::ST_DONE;
		res_value  = '0;
		emit       = 1'b1;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		at         = '0;
		case (act_q)
			kll_pkg::ACT_INSERT: begin
				if (key_q == kll_pkg::HEAD_KEY || hit_q) begin
					res_status = kll_pkg::ST_EXISTS;
				end else if (after_q != kll_pkg::HEAD_KEY && !pos_q) begin
					res_status = kll_pkg::ST_NOPOS;
				end else if (count_q == CNT_W'(CAPACITY)) begin
					res_status = kll_pkg::ST_FULL;
				end else begin
					do_ins = 1'b1;
					if (after_q != kll_pkg::HEAD_KEY) begin
						at = PW'(pos_idx_q) + PW'(1);
					end
				end
			end
			kll_pkg::ACT_DELETE: begin
				if (hit_q) begin
					do_del = 1'b1;
					at     = PW'(hit_idx_q);
				end else begin
					res_status = kll_pkg::ST_NOTFOUND;
				end
			end
			kll_pkg::ACT_FIND: begin
				if (!hit_q) begin
					res_status = kll_pkg::ST_NOTFOUND;
				end else if (hit_idx_q == '0) begin
					res_status = kll_pkg::ST_PREVHEAD;
				end else begin
					res_status = kll_pkg::ST_PREVKEY;
					res_value  = prev_key_q;
				end
			end
			default: begin
				res_status = kll_pkg::ST_EMPTY;
				emit       = (count_q == '0);
			end
		endcase
	end

	always_comb begin
		cmd.op  = kll_pkg::CELL_HOLD;
		cmd.key = key_q;
		cmd.at  = at;
		if (adv) begin
			cmd.op = kll_pkg::CELL_ROT;
		end else if (commit && do_ins) begin
			cmd.op = kll_pkg::CELL_INS;
		end else if (commit && do_del) begin
			cmd.op = kll_pkg::CELL_DEL;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			hit_q       <= 1'b0;
			pos_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						step_q  <= '0;
						hit_q   <= 1'b0;
						pos_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (adv) begin
						step_q <= step_q + IW'(1);
						if (c0.vld && !hit_q && c0.key == key_q) begin
							hit_q <= 1'b1;
						end
						if (c0.vld && !pos_q && c0.key == after_q) begin
							pos_q <= 1'b1;
						end
						if (is_print && c0.vld) begin
							rsp_valid_q <= 1'b1;
						end
						if (scan_end) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (emit) begin
							rsp_valid_q <= 1'b1;
						end
						if (do_ins) begin
							count_q <= count_q + CNT_W'(1);
						end else if (do_del) begin
							count_q <= count_q - CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and scan data
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			act_q   <= req.action;
			key_q   <= req.key;
			after_q <= req.after_key;
		end
		if (adv && c0.vld) begin
			if (!hit_q && c0.key == key_q) begin
				hit_idx_q <= step_q;
			end else if (!hit_q) begin
				prev_key_q <= c0.key;
			end
			if (!pos_q && c0.key == after_q) begin
				pos_idx_q <= step_q;
			end
			if (is_print) begin
				rsp_q.status <= kll_pkg::ST_ITEM;
				rsp_q.value  <= c0.key;
				rsp_q.last   <= scan_end || !nxt_vld;
			end
		end
		if (commit && emit) begin
			rsp_q.status <= res_status;
			rsp_q.value  <= res_value;
			rsp_q.last   <= 1'b1;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (c0.vld == (count_q != '0)))
		else $error("cell row not compacted at head");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && scan_end) |=> (state_q == S_DONE))
		else $error("scan did not end after a full rotation");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_ready) |=> rsp_valid_q && $stable(rsp_q))
		else $error("pending word lost or changed");

endmodule

// File: rtl/core/kll_cell.sv
`timescale 1ns / 1ps
// One list position: a valid bit and a key, loaded from either neighbor or from the command.
// Depends on kll_pkg.
module kll_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kll_pkg::cell_cmd_t cmd,
	input  kll_pkg::cell_t    lo,
	input  kll_pkg::cell_t    hi,
	output kll_pkg::cell_t    q
);

	localparam int unsigned PW = kll_pkg::POS_W;
	localparam logic [PW-1:0] MY_POS = PW'(IDX);

	logic                            vld_q;
	logic signed [kll_pkg::KEY_W-1:0] key_q;
	kll_pkg::cell_t                  nxt;
	logic                            load;

	always_comb begin
		nxt  = q;
		load = 1'b0;
		case (cmd.op)
			kll_pkg::CELL_ROT: begin
				nxt  = hi;
				load = 1'b1;
			end
			kll_pkg::CELL_INS: begin
				if (MY_POS == cmd.at) begin
					nxt.vld = 1'b1;
					nxt.key = cmd.key;
					load    = 1'b1;
				end else if (MY_POS > cmd.at) begin
					nxt  = lo;
					load = 1'b1;
				end
			end
			kll_pkg::CELL_DEL: begin
				if (MY_POS >= cmd.at) begin
					nxt  = hi;
					load = 1'b1;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= nxt.key;
		end
	end

	assign q.vld = vld_q;
	assign q.key = key_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench for keyed_linked_list_engine_unit: directed and random requests, every response
// word checked against a queue model of the ordered key list. Depends on kll_pkg and the RTL.
module testbench;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned RANDOM_WORDS = 420;
	localparam int unsigned STALL_LIMIT = 2000;

	typedef logic signed [kll_pkg::KEY_W-1:0] key_t;

	class list_scoreboard;
		key_t          chain[$];
		kll_pkg::rsp_t pending_words[$];
		int            errors;

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		function int position_of(key_t k);
			foreach (chain[i]) begin
				if (chain[i] == k) return i;
			end
			return -1;
		endfunction

		function void await_word(logic [3:0] status, key_t value, logic last);
			kll_pkg::rsp_t w;
			w.status = status;
			w.value  = value;
			w.last   = last;
			pending_words.push_back(w);
		endfunction

		function void note_request(kll_pkg::req_t w);
			int idx;
			int at;
			case (w.action)
			kll_pkg::ACT_INSERT: begin
				at = (w.after_key == kll_pkg::HEAD_KEY) ? 0
					: position_of(w.after_key) + 1;
				if (w.key == kll_pkg::HEAD_KEY || position_of(w.key) >= 0) begin
					await_word(kll_pkg::ST_EXISTS, '0, 1'b1);
				end else if (at == 0 && w.after_key != kll_pkg::HEAD_KEY) begin
					await_word(kll_pkg::ST_NOPOS, '0, 1'b1);
				end else if (chain.size() >= CAPACITY) begin
					await_word(kll_pkg::ST_FULL, '0, 1'b1);
				end else begin
					chain.insert(at, w.key);
					await_word(kll_pkg::ST_DONE, '0, 1'b1);
				end
			end
			kll_pkg::ACT_DELETE: begin
				idx = position_of(w.key);
				if (idx < 0) begin
					await_word(kll_pkg::ST_NOTFOUND, '0, 1'b1);
				end else begin
					chain.delete(idx);
					await_word(kll_pkg::ST_DONE, '0, 1'b1);
				end
			end
			kll_pkg::ACT_FIND: begin
				idx = position_of(w.key);
				if (idx < 0) await_word(kll_pkg::ST_NOTFOUND, '0, 1'b1);
				else if (idx == 0) await_word(kll_pkg::ST_PREVHEAD, '0, 1'b1);
				else await_word(kll_pkg::ST_PREVKEY, chain[idx-1], 1'b1);
			end
			default: begin
				if (chain.size() == 0) begin
					await_word(kll_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					foreach (chain[i])
						await_word(kll_pkg::ST_ITEM, chain[i], i == chain.size() - 1);
				end
			end
			endcase
		endfunction

		task check_response(kll_pkg::rsp_t got);
			kll_pkg::rsp_t want;
			if (pending_words.size() == 0) begin
				report($sformatf("unexpected word status %0d value %0d",
					got.status, got.value));
			end else begin
				want = pending_words.pop_front();
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.value !== want.value)
					report($sformatf("value %0d, want %0d", got.value, want.value));
				if (got.last !== want.last)
					report($sformatf("last %0b, want %0b", got.last, want.last));
			end
		endtask
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	kll_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_ready;
	kll_pkg::rsp_t  rsp;
	int             send_idle = 18;
	int             idle_cycles = 0;
	list_scoreboard sb = new;

	keyed_linked_list_engine_unit #(.CAPACITY(CAPACITY)) dut (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) sb.check_response(rsp);
			if (req_valid && req_ready) sb.note_request(req);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		int cyc;
		cyc = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 4000 && cyc < 4300) rsp_ready <= 1'b0;
			else if (cyc >= 9000 && cyc < 13000) rsp_ready <= 1'b1;
			else rsp_ready <= ($urandom_range(99) >= 18);
		end
	end

	function automatic kll_pkg::req_t make_word(logic [1:0] action, key_t k, key_t after);
		kll_pkg::req_t w;
		w.action    = action;
		w.key       = k;
		w.after_key = after;
		return w;
	endfunction

	function automatic key_t pick_key(bit fresh);
		int r;
		int sz;
		r  = $urandom_range(99);
		sz = sb.chain.size();
		if (r < (fresh ? 10 : 45) && sz > 0) return sb.chain[$urandom_range(sz - 1)];
		if (r < (fresh ? 50 : 72)) return key_t'(int'($urandom_range(80)) - 40);
		if (r < (fresh ? 58 : 82)) begin
			case ($urandom_range(3))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			default: return kll_pkg::HEAD_KEY;
			endcase
		end
		return key_t'($urandom);
	endfunction

	function automatic key_t pick_after();
		int r;
		int sz;
		r  = $urandom_range(99);
		sz = sb.chain.size();
		if (r < 30) return kll_pkg::HEAD_KEY;
		if (r < 85 && sz > 0) return sb.chain[$urandom_range(sz - 1)];
		return pick_key(1'b0);
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(kll_pkg::req_t w);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic run_random();
		kll_pkg::req_t w;
		bit            grow;
		int            r;
		int            sz;
		grow = 1'b1;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			send_idle = (n >= 150 && n < 230) ? 0 : 18;
			sz = sb.chain.size();
			// linger at a full pool for a few words, then drain
			if (grow && sz >= CAPACITY && $urandom_range(7) == 0) grow = 1'b0;
			if (!grow && sz <= 2) grow = 1'b1;
			r = $urandom_range(99);
			if (r < 5) w.action = kll_pkg::ACT_PRINT;
			else if (r < (grow ? 72 : 25)) w.action = kll_pkg::ACT_INSERT;
			else if (r < (grow ? 84 : 75)) w.action = kll_pkg::ACT_DELETE;
			else w.action = kll_pkg::ACT_FIND;
			w.key       = pick_key(w.action == kll_pkg::ACT_INSERT);
			w.after_key = pick_after();
			send_word(w);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(make_word(kll_pkg::ACT_PRINT,  0, 0));
		send_word(make_word(kll_pkg::ACT_FIND,   5, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, 5, 0));
		send_word(make_word(kll_pkg::ACT_INSERT, kll_pkg::HEAD_KEY, kll_pkg::HEAD_KEY));
		send_word(make_word(kll_pkg::ACT_INSERT, 10, kll_pkg::HEAD_KEY));
		send_word(make_word(kll_pkg::ACT_INSERT, 20, 99));
		send_word(make_word(kll_pkg::ACT_INSERT, 10, 99));
		send_word(make_word(kll_pkg::ACT_INSERT, 32'sh7fff_ffff, 10));
		send_word(make_word(kll_pkg::ACT_INSERT, 32'sh8000_0000, kll_pkg::HEAD_KEY));
		send_word(make_word(kll_pkg::ACT_INSERT, 0, 32'sh7fff_ffff));
		send_word(make_word(kll_pkg::ACT_INSERT, -2, 10));
		send_word(make_word(kll_pkg::ACT_PRINT,  0, 0));
		send_word(make_word(kll_pkg::ACT_FIND,   32'sh8000_0000, 0));
		send_word(make_word(kll_pkg::ACT_FIND,   0, 0));
		send_word(make_word(kll_pkg::ACT_FIND,   kll_pkg::HEAD_KEY, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, kll_pkg::HEAD_KEY, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, 32'sh8000_0000, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, -2, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, 0, 0));
		send_word(make_word(kll_pkg::ACT_FIND,   32'sh7fff_ffff, 0));
		send_word(make_word(kll_pkg::ACT_INSERT, 5, -2));
		send_word(make_word(kll_pkg::ACT_PRINT,  0, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, 10, 0));
		send_word(make_word(kll_pkg::ACT_DELETE, 32'sh7fff_ffff, 0));
		send_word(make_word(kll_pkg::ACT_PRINT,  0, 0));

		run_random();
		req_valid <= 1'b0;

		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (CAPACITY + 10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
